FILE: rtl/mts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody tone sequencer package
// Shared widths, codes and types for the melody tone sequencer.
// ----------------------------------------------------------------------------
package mts_pkg;

  // Sizing of the melody table and the oscillator.
  localparam int MELODY_DEPTH    = 16;
  localparam int PHASE_BITS      = 24;
  localparam int SINE_TABLE_BITS = 10;
  localparam int NOTE_W          = $clog2(MELODY_DEPTH);

  // Field and register widths.
  localparam int BEATS_W   = 8;
  localparam int STEP_W    = 24;
  localparam int IDX_W     = 4;
  localparam int SPB_W     = 16;
  localparam int AMP_W     = 15;
  localparam int MLEN_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int COUNT_W   = 20;
  localparam int SAMPLE_W  = 16;
  localparam int NOTENUM_W = 4;

  // Note length is (beats * samples_per_beat) >> 4.
  localparam int LEN_W    = BEATS_W + SPB_W - 4;
  // Divisor of the decay is five note lengths.
  localparam int DIV_W    = LEN_W + 3;
  // Envelope is a Q15 fraction, quotient bits produced by the divider.
  localparam int ENV_FRAC = 15;
  localparam int ENV_W    = ENV_FRAC + 1;
  localparam int QCNT_W   = $clog2(ENV_FRAC + 1);

  // Quarter-wave polynomial coefficients for sin(pi/2 * t), Q30.
  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598668;
  localparam logic [31:0] SIN_C5 = 32'd85569306;
  localparam logic [31:0] SIN_C7 = 32'd5026995;

  // Input operation codes, carried on in_tuser.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPB  = 2'd0,
    REG_AMP  = 2'd1,
    REG_MLEN = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [BEATS_W-1:0] beats;
    logic [STEP_W-1:0]  step;
  } entry_t;

  // Request to the envelope divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

endpackage

FILE: rtl/mts_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Envelope divider
// Restoring divider giving floor(num * 2^15 / den) for num below den.
// ----------------------------------------------------------------------------
module mts_div
  import mts_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  div_req_t            req,
  output logic                busy,
  output logic [ENV_FRAC-1:0] quotient
);

  logic [DIV_W-1:0]    rem_r;
  logic [DIV_W-1:0]    den_r;
  logic [ENV_FRAC-1:0] quo_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic [DIV_W:0]      rem_dbl;
  logic                fits;

  assign rem_dbl = {rem_r, 1'b0};
  assign fits    = rem_dbl >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      rem_r <= req.num;
      den_r <= req.den;
      quo_r <= '0;
      cnt_r <= QCNT_W'(ENV_FRAC);
    end else if (cnt_r != '0) begin
      // The remainder stays below the divisor, so one bit per step suffices.
      if (fits) begin
        rem_r <= DIV_W'(rem_dbl - {1'b0, den_r});
      end else begin
        rem_r <= DIV_W'(rem_dbl);
      end
      quo_r <= {quo_r[ENV_FRAC-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign busy     = cnt_r != '0;
  assign quotient = quo_r;

endmodule

FILE: rtl/melody_tone_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody tone sequencer core
// Looping melody player: note table, sine oscillator and note envelope.
// ----------------------------------------------------------------------------
// A write transfer (in_tuser high) loads one melody table slot in the cycle
// it is accepted and gives no result. A tick transfer (in_tuser low) produces
// exactly one output sample. A sounding note runs each tick through the
// envelope divider (a load, 15 quotient steps and a capture) and through
// eight passes of the one shared 32x32 multiplier (note length, five
// polynomial steps of the quarter-wave sine, and the two gain products).
// Once the envelope has decayed to zero the divider is skipped. A rest or a
// zero-length note skips the envelope and the sine and gives a zero sample.
// When a note ends, the sequencer wraps the note index at the melody length
// by repeated subtraction and then reads the next table slot. The input side
// is held off while a tick is in progress, but a finished sample sits in the
// output register, so the next transfer is taken while that sample waits; a
// tick that finishes while the output register is still full waits for it to
// empty.
// ----------------------------------------------------------------------------
module melody_tone_sequencer_core
  import mts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,   // entry_index[3:0], entry_beats[11:4],
                                           // entry_phase_step[35:12], zero[39:36]
  input  logic                 in_tuser,   // operation
  // Output stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // sample_out[15:0], note_number[19:16],
                                           // zero[23:20]
  output logic                 out_tuser,  // note_began
  // Configuration writes.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_LEN,
    S_CHECK,
    S_WRAP,
    S_ENV,
    S_DIV,
    S_SIN_T,
    S_SIN_T2,
    S_SIN_A,
    S_SIN_B,
    S_SIN_C,
    S_SIN_M,
    S_MAG,
    S_SAMPLE,
    S_DONE
  } state_t;

  localparam logic [NOTE_W:0] DEPTH_V = (NOTE_W + 1)'(MELODY_DEPTH);
  localparam int QTR_W = SINE_TABLE_BITS - 2;
  localparam int S50_W = COUNT_W + 6;

  // Melody table, no reset: a slot is only defined once it has been written.
  entry_t mem [MELODY_DEPTH];
  entry_t rd_data_r;

  state_t                state_r;
  logic [SPB_W-1:0]      spb_r;
  logic [AMP_W-1:0]      amp_r;
  logic [MLEN_W-1:0]     mlen_r;
  logic [NOTE_W-1:0]     cur_note_r;
  logic [COUNT_W-1:0]    count_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic                  checked_r;
  logic [NOTE_W:0]       wrap_v_r;
  logic [LEN_W-1:0]      len_r;
  logic [STEP_W-1:0]     step_r;
  logic [ENV_W-1:0]      env_r;
  logic [31:0]           t2_r;
  logic [AMP_W-1:0]      sinmag_r;
  logic [SAMPLE_W-1:0]   sample_r;
  logic [63:0]           mul_p_r;
  logic                  out_valid_r;
  logic [23:0]           out_data_r;
  logic                  out_user_r;

  logic                  in_fire;
  logic                  mem_we;
  logic [IDX_W-1:0]      wr_idx;
  entry_t                wr_entry;
  logic [NOTE_W:0]       mel_len;
  logic [LEN_W-1:0]      len_c;
  logic [31:0]           p_hi;
  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [S50_W-1:0]      s50;
  logic [DIV_W-1:0]      l5;
  logic [DIV_W-1:0]      s2;
  logic                  attack;
  logic                  decay_zero;
  div_req_t              div_req;
  logic                  div_busy;
  logic [ENV_FRAC-1:0]   div_quo;
  logic [SINE_TABLE_BITS-1:0] sin_idx;
  logic [QTR_W-1:0]      sin_r;
  logic [QTR_W:0]        sin_qi;
  logic [31:0]           sin_t;
  logic [16:0]           sin_round;
  logic [AMP_W-1:0]      mag;
  logic                  out_free;

  assign in_tready = state_r == S_IDLE;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Table write port and registered read of the current note.
  assign wr_idx         = in_tdata[3:0];
  assign wr_entry.beats = in_tdata[11:4];
  assign wr_entry.step  = in_tdata[35:12];
  assign mem_we = in_fire && (in_tuser == OP_WRITE)
                  && ((IDX_W + 1)'(wr_idx) < (IDX_W + 1)'(MELODY_DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[NOTE_W'(wr_idx)] <= wr_entry;
    end
    rd_data_r <= mem[cur_note_r];
  end

  // Effective loop length: zero counts as one, and it never exceeds the table.
  always_comb begin
    if (mlen_r == '0) begin
      mel_len = (NOTE_W + 1)'(1);
    end else if (int'(mlen_r) > MELODY_DEPTH) begin
      mel_len = DEPTH_V;
    end else begin
      mel_len = (NOTE_W + 1)'(mlen_r);
    end
  end

  // Product bits above the Q30 point, and the note length; each fits 32 bits.
  assign p_hi  = mul_p_r[61:30];
  assign len_c = mul_p_r[LEN_W+3:4];

  // Envelope set-up: attack over the first fiftieth of the note, then a
  // linear fall of 0.4 per note length, floored at zero.
  assign s50        = S50_W'(count_r) * S50_W'(50);
  assign l5         = DIV_W'(len_r) * DIV_W'(5);
  assign s2         = DIV_W'({count_r, 1'b0});
  assign attack     = s50 < S50_W'(len_r);
  assign decay_zero = s2 >= l5;

  assign div_req.start = (state_r == S_ENV) && (attack || !decay_zero);
  assign div_req.num   = attack ? DIV_W'(s50) : DIV_W'(l5 - s2);
  assign div_req.den   = attack ? DIV_W'(len_r) : l5;

  mts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Quarter-wave folding of the phase into the polynomial argument t (Q30).
  assign sin_idx = phase_r[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign sin_r   = sin_idx[QTR_W-1:0];
  assign sin_qi  = sin_idx[QTR_W] ? ((QTR_W + 1)'(1) << QTR_W) - {1'b0, sin_r}
                                  : {1'b0, sin_r};
  assign sin_t   = 32'(sin_qi) << (32 - SINE_TABLE_BITS);

  assign sin_round = 17'((p_hi + 32'd16384) >> 15);
  assign mag       = mul_p_r[30 + AMP_W - 1:30];

  // Operand selection for the shared multiplier; the product is registered
  // and consumed by the following state.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LEN: begin
        mul_a = 32'(rd_data_r.beats);
        mul_b = 32'(spb_r);
      end
      S_SIN_T: begin
        mul_a = sin_t;
        mul_b = sin_t;
      end
      S_SIN_T2: begin
        mul_a = SIN_C7;
        mul_b = p_hi;
      end
      S_SIN_A: begin
        mul_a = SIN_C5 - p_hi;
        mul_b = t2_r;
      end
      S_SIN_B: begin
        mul_a = SIN_C3 - p_hi;
        mul_b = t2_r;
      end
      S_SIN_C: begin
        mul_a = SIN_C1 - p_hi;
        mul_b = sin_t;
      end
      S_SIN_M: begin
        mul_a = 32'(env_r);
        mul_b = 32'(amp_r);
      end
      S_MAG: begin
        mul_a = mul_p_r[31:0];
        mul_b = 32'(sinmag_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= 64'(mul_a) * 64'(mul_b);
  end

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      spb_r       <= SPB_W'(12000);
      amp_r       <= AMP_W'(16384);
      mlen_r      <= MLEN_W'(1);
      cur_note_r  <= '0;
      count_r     <= '0;
      phase_r     <= '0;
      checked_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SPB:  spb_r  <= cfg_wdata[SPB_W-1:0];
          REG_AMP:  amp_r  <= cfg_wdata[AMP_W-1:0];
          REG_MLEN: mlen_r <= cfg_wdata[MLEN_W-1:0];
          default:  ;
        endcase
      end

      // A finished sample loads the output register; otherwise a completed
      // output transfer empties it.
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire && (in_tuser == OP_TICK)) begin
            checked_r <= 1'b0;
            state_r   <= S_FETCH;
          end
        end
        S_FETCH: begin
          state_r <= S_LEN;
        end
        S_LEN: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          // The end-of-note test is made once per tick, on the note in hand.
          if (!checked_r && (count_r >= len_c)) begin
            wrap_v_r  <= (NOTE_W + 1)'(cur_note_r) + 1'b1;
            count_r   <= '0;
            phase_r   <= '0;
            checked_r <= 1'b1;
            state_r   <= S_WRAP;
          end else begin
            len_r  <= len_c;
            step_r <= rd_data_r.step;
            if ((PHASE_BITS'(rd_data_r.step) == '0) || (len_c == '0)) begin
              sample_r <= '0;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_ENV;
            end
          end
        end
        S_WRAP: begin
          // Remainder by repeated subtraction; the index is usually in range.
          if (wrap_v_r >= mel_len) begin
            wrap_v_r <= wrap_v_r - mel_len;
          end else begin
            cur_note_r <= wrap_v_r[NOTE_W-1:0];
            state_r    <= S_FETCH;
          end
        end
        S_ENV: begin
          if (attack || !decay_zero) begin
            state_r <= S_DIV;
          end else begin
            env_r   <= '0;
            state_r <= S_SIN_T;
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            env_r   <= ENV_W'(div_quo);
            state_r <= S_SIN_T;
          end
        end
        S_SIN_T: begin
          state_r <= S_SIN_T2;
        end
        S_SIN_T2: begin
          t2_r    <= p_hi;
          state_r <= S_SIN_A;
        end
        S_SIN_A: begin
          state_r <= S_SIN_B;
        end
        S_SIN_B: begin
          state_r <= S_SIN_C;
        end
        S_SIN_C: begin
          state_r <= S_SIN_M;
        end
        S_SIN_M: begin
          // Round the Q30 sine to Q15 and cap at the largest positive value.
          sinmag_r <= (sin_round > 17'd32767) ? AMP_W'(32767) : AMP_W'(sin_round);
          state_r  <= S_MAG;
        end
        S_MAG: begin
          state_r <= S_SAMPLE;
        end
        S_SAMPLE: begin
          sample_r <= sin_idx[SINE_TABLE_BITS-1] ? SAMPLE_W'(-SAMPLE_W'(mag))
                                                 : SAMPLE_W'(mag);
          phase_r  <= phase_r + PHASE_BITS'(step_r);
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r  <= {4'b0000, NOTENUM_W'(cur_note_r), sample_r};
            out_user_r  <= count_r == '0;
            if (count_r != '1) begin
              count_r <= count_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: rtl/mts_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody tone sequencer checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
module mts_chk
  import mts_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 in_tuser,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [23:0]          out_tdata,
  input logic                 out_tuser
);

  // A waiting sample is neither dropped nor altered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output transfer dropped or changed while stalled");

  // A tick keeps the input side busy while the sample is computed.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_TICK) |=> !in_tready)
    else $error("input accepted during a tick");

  // A table write completes in its own cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_WRITE) |=> in_tready)
    else $error("table write stalled the input");

  // A new sample only appears at the end of a tick.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("sample produced without a tick in progress");

endmodule

bind melody_tone_sequencer_core mts_chk u_mts_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: dv/melody_tone_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody tone sequencer core testbench
// Self-checking bench that drives note table writes and sample ticks into the
// core and compares every sample against a cycle-free model of the melody.
// ----------------------------------------------------------------------------
// Structure:
//   - A short directed walk loads the extremes of the note fields, covers
//     rests, zero-length notes and an out-of-range melody length, and pins the
//     few samples that are obvious by inspection.
//   - Eight random phases follow. Each starts from an idle core, reprograms
//     all three registers, makes sure every slot inside the melody loop has
//     been loaded, then mixes ticks with table writes.
//   - The phases rotate through four idling patterns on the two streams. One
//     phase also holds the output side off for a long stretch, so that the
//     core fills up and back-pressures its input.
// Each tick transfer is run through the local model of the sequencer at the
// clock edge where it is accepted, and the resulting sample is queued. Output
// transfers are compared, field by field, with the head of that queue.
// ----------------------------------------------------------------------------
module melody_tone_sequencer_core_tb;
  import mts_pkg::*;

  localparam int          RESET_CYCLES = 10;
  // Drain time of settle(): it covers a sounding tick together with a note
  // change and a wrap of the note index through every slot.
  localparam int          DRAIN_CYCLES = 100;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          PHASES       = 8;
  localparam int          PHASE_ITEMS  = 50;
  localparam int          PRINT_CAP    = 100;
  localparam longint unsigned QUARTER  = 64'd1 << (SINE_TABLE_BITS - 2);

  typedef struct packed {
    logic [SAMPLE_W-1:0]  sample;
    logic [NOTENUM_W-1:0] note;
    logic                 began;
  } tone_result_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_WRITE,
    ROW_TICK
  } row_kind_t;

  // One row of the directed walk. A tick row may pin its expected sample;
  // otherwise the model decides.
  typedef struct packed {
    row_kind_t          kind;
    cfg_reg_t           reg_sel;
    logic [CFG_W-1:0]   value;
    logic [IDX_W-1:0]   slot;
    logic [BEATS_W-1:0] beats;
    logic [STEP_W-1:0]  step;
    logic               pinned;
    tone_result_t       pinned_res;
  } plan_row_t;

  localparam tone_result_t NOTE_START_SILENT = '{16'd0, 4'd0, 1'b1};

  localparam plan_row_t DIRECTED_PLAN [24] = '{
    '{ROW_CFG,   REG_AMP,  16'd32767, 4'd0, 8'd0,   24'd0,        1'b0, '0},
    '{ROW_CFG,   REG_SPB,  16'd16,    4'd0, 8'd0,   24'd0,        1'b0, '0},
    // A melody length of zero is taken as a loop of one slot.
    '{ROW_CFG,   REG_MLEN, 16'd0,     4'd0, 8'd0,   24'd0,        1'b0, '0},
    // Zero-length rest: every tick ends the note and restarts it silently.
    '{ROW_WRITE, REG_SPB,  16'd0,     4'd0, 8'd0,   24'd0,        1'b0, '0},
    '{ROW_TICK,  REG_SPB,  16'd0,     4'd0, 8'd0,   24'd0,        1'b1, NOTE_START_SILENT},
    '{ROW_TICK,  REG_SPB,  16'd0,     4'd0, 8'd0,   24'd0,        1'b1, NOTE_START_SILENT},
    // Longest note and widest phase step.
    '{ROW_WRITE, REG_SPB,  16'd0,     4'd0, 8'hff,  24'hffffff,   1'b0, '0},
    '{ROW_TICK,  REG_SPB,  16'd0,     4'd0, 8'd0,   24'd0,        1'b0, '0},
    '{ROW_TICK,  REG_SPB,  16'd0,     4'd0, 8'd0,   24'd0,        1'b0, '0},
    '{ROW_TICK,  REG_SPB,  16'd0,     4'd0, 8'd0,   24'd0,        1'b0, '0},
    '{ROW_TICK,  REG_SPB,  16'd0,     4'd0, 8'd0,   24'd0,        1'b0, '0},
    // A one-sample note, a sounding note of zero length and a rest.
    '{ROW_WRITE, REG_SPB,  16'd0,     4'd1, 8'h01,  24'h400000,   1'b0, '0},
    '{ROW_WRITE, REG_SPB,  16'd0,     4'd2, 8'h00,  24'h123456,   1'b0, '0},
    '{ROW_WRITE, REG_SPB,  16'd0,     4'd3, 8'h10,  24'h000000,   1'b0, '0},
    // Shorten the note that is playing, so the next tick moves on.
    '{ROW_WRITE, REG_SPB,  16'd0,     4'd0, 8'h02,  24'h000001,   1'b0, '0},
    '{ROW_CFG,   REG_MLEN, 16'd4,     4'd0, 8'd0,   24'd0,        1'b0, '0},
    '{ROW_TICK,  REG_SPB,  16'd0,     4'd0, 8'd0,   24'd0,        1'b0, '0},
    '{ROW_TICK,  REG_SPB,  16'd0,     4'd0, 8'd0,   24'd0,        1'b0, '0},
    '{ROW_TICK,  REG_SPB,  16'd0,     4'd0, 8'd0,   24'd0,        1'b0, '0},
    '{ROW_TICK,  REG_SPB,  16'd0,     4'd0, 8'd0,   24'd0,        1'b0, '0},
    '{ROW_TICK,  REG_SPB,  16'd0,     4'd0, 8'd0,   24'd0,        1'b0, '0},
    '{ROW_TICK,  REG_SPB,  16'd0,     4'd0, 8'd0,   24'd0,        1'b0, '0},
    '{ROW_TICK,  REG_SPB,  16'd0,     4'd0, 8'd0,   24'd0,        1'b0, '0},
    '{ROW_TICK,  REG_SPB,  16'd0,     4'd0, 8'd0,   24'd0,        1'b0, '0}
  };

  // Register settings of the random phases, the extremes among them. Melody
  // lengths of zero and above the table depth are folded by the core.
  localparam logic [SPB_W-1:0]  SPB_PLAN  [PHASES] = '{
    16'd3, 16'd1, 16'd24, 16'd65535, 16'd100, 16'd12000, 16'd7, 16'd40};
  localparam logic [AMP_W-1:0]  AMP_PLAN  [PHASES] = '{
    15'd20000, 15'd32767, 15'd0, 15'd32767, 15'd9000, 15'd1, 15'd12345, 15'd16384};
  localparam logic [MLEN_W-1:0] MLEN_PLAN [PHASES] = '{
    5'd2, 5'd16, 5'd31, 5'd5, 5'd0, 5'd17, 5'd1, 5'd9};

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [39:0]          in_tdata   = '0;
  logic                 in_tuser   = OP_TICK;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;
  logic                 out_tuser;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  // Pinned expectation travelling alongside the tick on the input stream.
  logic                 tick_pinned     = 1'b0;
  tone_result_t         tick_pinned_res = '0;

  // Idling of the two streams, in percent of cycles.
  int unsigned          send_rate     = 0;
  int unsigned          stall_rate    = 0;
  int unsigned          hold_requests = 0;
  int unsigned          hold_served   = 0;
  int unsigned          hold_left     = 0;

  int unsigned          mismatch_count = 0;
  int unsigned          cycle_count    = 0;
  logic [MELODY_DEPTH-1:0] slots_loaded = '0;

  tone_result_t         expected_samples [$];

  // Local copy of the sequencer state and its registers.
  entry_t               melody_mem [MELODY_DEPTH];
  logic [NOTE_W-1:0]    cur_note  = '0;
  logic [COUNT_W-1:0]   note_pos  = '0;
  logic [PHASE_BITS-1:0] phase_acc = '0;
  logic [SPB_W-1:0]     spb_reg   = 16'd12000;
  logic [AMP_W-1:0]     amp_reg   = 15'd16384;
  logic [MLEN_W-1:0]    mlen_reg  = 5'd1;

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  melody_tone_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Model of the sequencer
  // --------------------------------------------------------------------------

  // Q15 magnitude of one quarter-wave point, from the odd seventh-order
  // polynomial with truncating shifts, rounded and capped at full scale.
  function automatic longint unsigned quarter_sine_q15(input longint unsigned qi);
    longint unsigned t, t2, a, b, c, s, m;
    t  = qi << (32 - SINE_TABLE_BITS);
    t2 = (t * t) >> 30;
    a  = 64'(SIN_C5) - ((64'(SIN_C7) * t2) >> 30);
    b  = 64'(SIN_C3) - ((a * t2) >> 30);
    c  = 64'(SIN_C1) - ((b * t2) >> 30);
    s  = (c * t) >> 30;
    m  = (s + 64'd16384) >> 15;
    return (m > 64'd32767) ? 64'd32767 : m;
  endfunction

  function automatic longint unsigned note_samples(input entry_t e);
    return (64'(e.beats) * 64'(spb_reg)) >> 4;
  endfunction

  // Advances the melody by one tick and returns the sample it plays.
  function automatic tone_result_t play_tick();
    entry_t          e;
    longint unsigned len, s, env, idx, quad, r, sinmag, mag;
    int unsigned     loop_len;
    tone_result_t    res;
    e = melody_mem[cur_note];
    if (64'(note_pos) >= note_samples(e)) begin
      loop_len = (mlen_reg == 0) ? 1 :
                 (int'(mlen_reg) > MELODY_DEPTH) ? MELODY_DEPTH : int'(mlen_reg);
      cur_note  = NOTE_W'((int'(cur_note) + 1) % loop_len);
      note_pos  = '0;
      phase_acc = '0;
    end
    e   = melody_mem[cur_note];
    len = note_samples(e);
    s   = 64'(note_pos);
    res.sample = '0;
    // Rests and zero-length notes are silent and leave the phase alone.
    if (e.step != '0 && len != 0) begin
      if (s * 50 < len)
        env = (s * 50 * 32768) / len;
      else if (2 * s >= 5 * len)
        env = 0;
      else
        env = ((5 * len - 2 * s) * 32768) / (5 * len);
      idx    = 64'(phase_acc) >> (PHASE_BITS - SINE_TABLE_BITS);
      quad   = (idx >> (SINE_TABLE_BITS - 2)) & 64'd3;
      r      = idx & (QUARTER - 1);
      sinmag = quarter_sine_q15(quad[0] ? QUARTER - r : r);
      mag    = (env * 64'(amp_reg) * sinmag) >> 30;
      res.sample = (quad >= 2) ? SAMPLE_W'(64'd0 - mag) : SAMPLE_W'(mag);
      phase_acc  = phase_acc + e.step;
    end
    res.note  = cur_note;
    res.began = (note_pos == '0);
    if (note_pos != '1)
      note_pos = note_pos + 1'b1;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Everything is sampled at the clock edge, before the core's own updates of
  // that edge land, so the order of processes within the step does not matter.
  always @(posedge clk) begin : scoreboard
    tone_result_t want;
    entry_t       loaded;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected output transfer", 32'(out_tdata), 32'd0);
        end else begin
          want = expected_samples.pop_front();
          if (out_tdata[15:0] !== want.sample)
            report_mismatch("sample_out", 32'(out_tdata[15:0]), 32'(want.sample));
          if (out_tdata[19:16] !== want.note)
            report_mismatch("note_number", 32'(out_tdata[19:16]), 32'(want.note));
          if (out_tuser !== want.began)
            report_mismatch("note_began", 32'(out_tuser), 32'(want.began));
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SPB:  spb_reg  = cfg_wdata[SPB_W-1:0];
          REG_AMP:  amp_reg  = cfg_wdata[AMP_W-1:0];
          REG_MLEN: mlen_reg = cfg_wdata[MLEN_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_WRITE) begin
          loaded.beats = in_tdata[11:4];
          loaded.step  = in_tdata[35:12];
          melody_mem[in_tdata[3:0]] = loaded;
        end else begin
          want = play_tick();
          if (tick_pinned)
            want = tick_pinned_res;
          expected_samples.push_back(want);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output side: random stalls, plus a long hold-off counted here on request.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : receiver
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(stall_rate != 0 && $urandom_range(99) < stall_rate);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("melody_tone_sequencer_core regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offers one transfer, with random gaps before it when the sender idles,
  // and returns once the core has accepted it.
  task automatic offer_item(input logic op, input logic [39:0] data,
                            input logic pinned, input tone_result_t pinned_res);
    while (send_rate != 0 && $urandom_range(99) < send_rate) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid       <= 1'b1;
    in_tuser        <= op;
    in_tdata        <= data;
    tick_pinned     <= pinned;
    tick_pinned_res <= pinned_res;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
  endtask

  task automatic load_slot(input logic [IDX_W-1:0] slot, input logic [BEATS_W-1:0] beats,
                           input logic [STEP_W-1:0] step);
    slots_loaded[slot] = 1'b1;
    offer_item(OP_WRITE, {4'h0, step, beats, slot}, 1'b0, '0);
  endtask

  // Tick transfers carry random data bits, which the core has to ignore.
  function automatic logic [39:0] tick_noise();
    return {4'h0, 4'($urandom), 32'($urandom)};
  endfunction

  // Mostly short notes, so that notes end often, with zero lengths and the
  // full range mixed in.
  function automatic logic [BEATS_W-1:0] pick_beats();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10)
      return '0;
    if (roll < 75)
      return BEATS_W'($urandom_range(1, 40));
    return BEATS_W'($urandom);
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15)
      return '0;
    if (roll < 25) begin
      case ($urandom_range(3))
        0: return 24'hffffff;
        1: return 24'h000001;
        2: return 24'h800000;
        default: return 24'h400000;
      endcase
    end
    return STEP_W'($urandom);
  endfunction

  // Waits until every sample has come back, then lets the core settle, since
  // a table write may still be in flight after the last sample.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES)
      @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t sel, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t         row;
    int unsigned       loop_len;
    logic [MLEN_W-1:0] mlen_pick;
    logic [AMP_W-1:0]  amp_pick;

    repeat (RESET_CYCLES)
      @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk, with both streams running freely.
    for (int i = 0; i < $size(DIRECTED_PLAN); i++) begin
      row = DIRECTED_PLAN[i];
      case (row.kind)
        ROW_CFG: begin
          settle();
          write_register(row.reg_sel, row.value);
        end
        ROW_WRITE: load_slot(row.slot, row.beats, row.step);
        default:   offer_item(OP_TICK, tick_noise(), row.pinned, row.pinned_res);
      endcase
    end

    // Random phases. Each one starts from an idle core, so the sender has
    // paused until every sample of the previous phase has been taken.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p % 4)
        0: begin
          send_rate  = 0;
          stall_rate = 0;
        end
        1: begin
          send_rate  = 58;
          stall_rate = 0;
        end
        2: begin
          send_rate  = 0;
          stall_rate = 58;
        end
        default: begin
          send_rate  = 9;
          stall_rate = 9;
        end
      endcase
      mlen_pick = MLEN_PLAN[p];
      amp_pick  = (p == 6) ? AMP_W'($urandom) : AMP_PLAN[p];
      // Bits above each register's width are filled with noise.
      write_register(REG_SPB, SPB_PLAN[p]);
      write_register(REG_AMP, {1'($urandom), amp_pick});
      write_register(REG_MLEN, {11'($urandom), mlen_pick});

      // No slot inside the loop may be played before it has been loaded.
      loop_len = (mlen_pick == 0) ? 1 :
                 (int'(mlen_pick) > MELODY_DEPTH) ? MELODY_DEPTH : int'(mlen_pick);
      for (int k = 0; k < loop_len; k++) begin
        if (!slots_loaded[k])
          load_slot(IDX_W'(k), BEATS_W'($urandom_range(1, 24)), pick_step());
      end

      // With the sender running flat out, hold the output side off so the
      // core fills up and stops taking transfers.
      if (p == 4)
        hold_requests++;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 20)
          load_slot(IDX_W'($urandom), pick_beats(), pick_step());
        else
          offer_item(OP_TICK, tick_noise(), 1'b0, '0);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("melody_tone_sequencer_core regression: pass");
    end else begin
      $display("melody_tone_sequencer_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: melody_tone_sequencer_core.f
rtl/mts_pkg.sv
rtl/mts_div.sv
rtl/melody_tone_sequencer_core.sv
rtl/mts_chk.sv
dv/melody_tone_sequencer_core_tb.sv
